@@ src/tbtw_pkg.sv @@
// Shared types, codes and the cosine-ramp table function for the band taper weight block.
// Used by the top level and the pipelined ramp divider; no dependencies.
package tbtw_pkg;

    // Field widths fixed by the block's interface
    localparam int UV_W     = 32;
    localparam int WEIGHT_W = 17;
    localparam int CFG_IDX_W = 8;

    // Region codes of a result beat
    typedef logic [1:0] t_region;
    localparam t_region REGION_OUTSIDE = 2'd0;
    localparam t_region REGION_INNER   = 2'd1;
    localparam t_region REGION_FLAT    = 2'd2;
    localparam t_region REGION_OUTER   = 2'd3;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MIN_UV      = 8'd0;
    localparam t_cfg_idx CFG_MAX_UV      = 8'd1;
    localparam t_cfg_idx CFG_INNER_WIDTH = 8'd2;
    localparam t_cfg_idx CFG_OUTER_WIDTH = 8'd3;

    typedef logic [WEIGHT_W-1:0] t_weight;
    localparam t_weight WEIGHT_ONE  = 17'h10000;
    localparam t_weight WEIGHT_ZERO = 17'h00000;

    // Control that travels alongside each item in the pipeline
    typedef struct packed {
        logic    valid;
        t_region region;
    } t_tag;

    // pi in Q2.62
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

    // (a * b) >> 62, low 64 bits kept
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Shift-subtract long division, used only when building the table
    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 65536 * sin^2(pi * t / 2^(pb+1)), rounded half up, via a Taylor series in Q2.62
    function automatic t_weight ramp_value(input int unsigned t, input int pb);
        logic [63:0] base;
        logic [63:0] ang;
        logic [63:0] a2;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] den;
        logic [63:0] sq;
        logic [63:0] w;
        int          k;
        base = PI_Q62 >> 17;
        ang  = (base * 64'(t)) << (16 - pb);
        a2   = mul_q62(ang, ang);
        s    = ang;
        term = ang;
        k    = 1;
        while (k < 40 && term != 64'd0) begin
            den  = 64'((2 * k) * (2 * k + 1));
            term = long_div(mul_q62(term, a2), den);
            if (k[0]) begin
                s = s - term;
            end else begin
                s = s + term;
            end
            k++;
        end
        sq = mul_q62(s, s);
        w  = (sq + (64'd1 << 45)) >> 46;
        if (w > 64'd65536) begin
            w = 64'd65536;
        end
        return w[WEIGHT_W-1:0];
    endfunction

endpackage

@@ src/tukey_band_taper_weight_top.sv @@
// Top level of the band taper weight block: config registers, classify stage, ROM and output.
// Depends on tbtw_pkg and tbtw_ramp_div.
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_stall          i_uv_distance
//  result    out        o_valid / i_stall          o_weight, o_region
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat enters per cycle while o_stall is low; beats pass the input, classify, divider, ROM
// and output registers in turn, and the divider resolves one phase bit per stage.
// Reset is synchronous, active low, clears the valid bits and resets the config registers.
// An output register plus a one-beat skid register part the two sides; o_stall rises only
// when the skid register is full, and then the whole pipeline holds.
// The config port is always ready.
module tukey_band_taper_weight_top #(
    parameter int PHASE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_uv_distance,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_weight,
    output logic [1:0]  o_region,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int TABLE_LEN = (1 << PHASE_BITS) + 1;
    localparam int IDX_W     = PHASE_BITS + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_LEN - 1);

    // Configuration registers
    logic [31:0] r_min_uv;
    logic [31:0] r_max_uv;
    logic [31:0] r_inner_width;
    logic [31:0] r_outer_width;

    // Pipeline enable
    logic w_en;

    // Input stage
    logic        r_in_v;
    logic [31:0] r_d;

    // Classify stage
    logic [32:0]       w_in_end;
    logic [32:0]       w_d_plus;
    logic              w_on_inner;
    tbtw_pkg::t_region w_region;
    tbtw_pkg::t_tag    r_cls_tag;
    logic [31:0]       r_x;
    logic [31:0]       r_n;

    // Divider output
    tbtw_pkg::t_tag    w_div_tag;
    logic [IDX_W-1:0]  w_q;
    logic [IDX_W-1:0]  w_idx;

    // ROM stage
    tbtw_pkg::t_weight w_rom [TABLE_LEN];
    tbtw_pkg::t_tag    r_rom_tag;
    tbtw_pkg::t_weight r_rom_w;

    // Output and skid registers
    logic              w_take;
    logic              w_arrive;
    logic              r_out_v;
    tbtw_pkg::t_weight r_out_w;
    tbtw_pkg::t_region r_out_region;
    logic              r_skid_v;
    tbtw_pkg::t_weight r_skid_w;
    tbtw_pkg::t_region r_skid_region;

    // Write config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_uv      <= 32'h0000_0000;
            r_max_uv      <= 32'hFFFF_FFFF;
            r_inner_width <= 32'h0000_0000;
            r_outer_width <= 32'h0000_0000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tbtw_pkg::CFG_MIN_UV:      r_min_uv      <= i_cfg_data;
                tbtw_pkg::CFG_MAX_UV:      r_max_uv      <= i_cfg_data;
                tbtw_pkg::CFG_INNER_WIDTH: r_inner_width <= i_cfg_data;
                tbtw_pkg::CFG_OUTER_WIDTH: r_outer_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold everything while the skid register is occupied
    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_en) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d <= i_uv_distance;
        end
    end

    // Classify: band edges, flat part, ramp side; inner ramp wins on overlap
    assign w_in_end   = {1'b0, r_min_uv} + {1'b0, r_inner_width};
    assign w_d_plus   = {1'b0, r_d} + {1'b0, r_outer_width};
    assign w_on_inner = ({1'b0, r_d} <= w_in_end);

    always_comb begin
        priority if (r_d <= r_min_uv || r_d >= r_max_uv) begin
            w_region = tbtw_pkg::REGION_OUTSIDE;
        end else if (w_in_end < {1'b0, r_d} && w_d_plus < {1'b0, r_max_uv}) begin
            w_region = tbtw_pkg::REGION_FLAT;
        end else if (w_on_inner) begin
            w_region = tbtw_pkg::REGION_INNER;
        end else begin
            w_region = tbtw_pkg::REGION_OUTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_tag.valid <= 1'b0;
        end else if (w_en) begin
            r_cls_tag.valid  <= r_in_v;
            r_cls_tag.region <= w_region;
        end
    end

    // Ramp position and width for the divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x <= w_on_inner ? (r_d - r_min_uv) : (r_max_uv - r_d);
            r_n <= w_on_inner ? r_inner_width : r_outer_width;
        end
    end

    // Phase t = floor(x * 2^PHASE_BITS / n)
    tbtw_ramp_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (r_cls_tag),
        .i_x     (r_x),
        .i_n     (r_n),
        .o_tag   (w_div_tag),
        .o_q     (w_q)
    );

    // Cosine ramp table, built at elaboration
    for (genvar g = 0; g < TABLE_LEN; g++) begin : g_rom
        localparam tbtw_pkg::t_weight ENTRY = tbtw_pkg::ramp_value(g, PHASE_BITS);
        assign w_rom[g] = ENTRY;
    end

    // Clamp phases past the ramp end to the last entry
    assign w_idx = w_q[IDX_W-1] ? IDX_LAST : w_q;

    // Look up the weight and pick it by region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_tag.valid <= 1'b0;
        end else if (w_en) begin
            r_rom_tag <= w_div_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            unique case (w_div_tag.region)
                tbtw_pkg::REGION_INNER,
                tbtw_pkg::REGION_OUTER:   r_rom_w <= w_rom[w_idx];
                tbtw_pkg::REGION_FLAT:    r_rom_w <= tbtw_pkg::WEIGHT_ONE;
                tbtw_pkg::REGION_OUTSIDE: r_rom_w <= tbtw_pkg::WEIGHT_ZERO;
            endcase
        end
    end

    // Output register with a one-beat skid behind it
    assign w_take   = r_out_v && !i_stall;
    assign w_arrive = w_en && r_rom_tag.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_arrive) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out_w      <= r_skid_w;
                r_out_region <= r_skid_region;
            end
        end else if (w_arrive) begin
            if (!r_out_v || w_take) begin
                r_out_w      <= r_rom_w;
                r_out_region <= r_rom_tag.region;
            end else begin
                r_skid_w      <= r_rom_w;
                r_skid_region <= r_rom_tag.region;
            end
        end
    end

    assign o_valid  = r_out_v;
    assign o_weight = r_out_w;
    assign o_region = r_out_region;

`ifndef SYNTH
    // The skid register is only ever filled behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");

    // The skid register fills only when the output beat was stalled
    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid register filled without an output stall");

    // Flat and outside beats carry fixed weights
    a_fixed_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_region == tbtw_pkg::REGION_FLAT || o_region == tbtw_pkg::REGION_OUTSIDE))
        |-> (o_weight == ((o_region == tbtw_pkg::REGION_FLAT) ?
                          tbtw_pkg::WEIGHT_ONE : tbtw_pkg::WEIGHT_ZERO)))
        else $error("weight does not match region");

    // A held output beat stays put while the skid register is full
    a_hold_with_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_stall) |=> (r_out_v && $stable(r_out_w) && $stable(r_out_region)))
        else $error("output beat changed while stalled behind skid");
`endif

endmodule

@@ src/tbtw_ramp_div.sv @@
// Pipelined restoring divider for the ramp phase t = floor(x * 2^PHASE_BITS / n), x <= n.
// One quotient bit per stage; depends on tbtw_pkg for the item tag.
module tbtw_ramp_div #(
    parameter int PHASE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  tbtw_pkg::t_tag        i_tag,
    input  logic [31:0]           i_x,
    input  logic [31:0]           i_n,
    output tbtw_pkg::t_tag        o_tag,
    output logic [PHASE_BITS:0]   o_q
);

    localparam int STEPS = PHASE_BITS + 1;

    // Partial remainder and divisor for every stage but the last
    logic [31:0]         r_rem [PHASE_BITS];
    logic [31:0]         r_n   [PHASE_BITS];
    logic [PHASE_BITS:0] r_q   [STEPS];
    tbtw_pkg::t_tag      r_tag [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [32:0]         w_rem_in;
        logic [31:0]         w_n_in;
        logic [PHASE_BITS:0] w_q_in;
        tbtw_pkg::t_tag      w_tag_in;
        logic [32:0]         w_diff;
        logic                w_ge;

        // First step weighs 2^PHASE_BITS and takes x unshifted
        if (j == 0) begin : g_first
            assign w_rem_in = {1'b0, i_x};
            assign w_n_in   = i_n;
            assign w_q_in   = '0;
            assign w_tag_in = i_tag;
        end else begin : g_next
            assign w_rem_in = {r_rem[j-1], 1'b0};
            assign w_n_in   = r_n[j-1];
            assign w_q_in   = r_q[j-1];
            assign w_tag_in = r_tag[j-1];
        end

        // Trial subtract and compare
        assign w_diff = w_rem_in - {1'b0, w_n_in};
        assign w_ge   = (w_rem_in >= {1'b0, w_n_in});

        // Advance the tag; reset clears the valid bit only
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[j].valid <= 1'b0;
            end else if (i_en) begin
                r_tag[j] <= w_tag_in;
            end
        end

        // Shift in the new quotient bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j] <= {w_q_in[PHASE_BITS-1:0], w_ge};
            end
        end

        // Keep the remainder and divisor for the next step
        if (j < PHASE_BITS) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? w_diff[31:0] : w_rem_in[31:0];
                    r_n[j]   <= w_n_in;
                end
            end
        end
    end

    assign o_tag = r_tag[PHASE_BITS];
    assign o_q   = r_q[PHASE_BITS];

endmodule
